// File: design/running_median_assert.svh
// Assertion macros shared by the running median block.
`ifndef RUNNING_MEDIAN_ASSERT_SVH
`define RUNNING_MEDIAN_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define RMED_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define RMED_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/rmed_pkg.sv
`timescale 1ns / 1ps

package rmed_pkg;

	typedef struct packed {
		logic signed [31:0] sample;
		logic               start_new;
	} rmed_req_t;

	typedef struct packed {
		logic signed [31:0] median_out;
		logic [6:0]         sample_count;
		logic               dropped;
	} rmed_rsp_t;

	// Per-cell insertion control.
	typedef struct packed {
		logic wr;    // insertion happens this cycle
		logic held;  // cell lies below the fill level
		logic tail;  // cell is the first free slot
	} rmed_cell_ctl_t;

	typedef enum logic [1:0] {
		RMED_IDLE,
		RMED_WAIT,
		RMED_FINISH
	} rmed_state_t;

endpackage

// File: design/running_median.sv
`timescale 1ns / 1ps
// Running median of a signed sample stream.
// Input channel: sample_valid / sample_stall / sample_req. Each request carries
// one sample (low SAMPLE_WIDTH bits, two's complement) and start_new, which
// empties the store before the sample goes in.
// Output channel: result_valid / result_stall / result. One result per request:
// median of the held samples (even count: middle pair averaged, truncated
// toward zero), the fill count and a dropped flag for a sample that met a full
// store.
// Samples sit in a row of CAPACITY cells kept in ascending order; a sample
// enters in the cycle it is accepted, larger cells shifting one place up.
// The two middle cells are then collected by two registered OR trees of
// log2(CAPACITY)+1 stages.
// sample_stall holds off a new request until the result of the last one is
// loaded, a wait set by the tree depth; the next request is taken while a
// result still waits.
// result_stall holds the result register; the block waits in its final step
// until the register is free.
// Reset empties the store (count zero); cell contents are left as they are.

module running_median
	import rmed_pkg::*;
#(
	parameter int CAPACITY     = 64,
	parameter int SAMPLE_WIDTH = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      sample_valid,
	output logic      sample_stall,
	input  rmed_req_t sample_req,
	output logic      result_valid,
	input  logic      result_stall,
	output rmed_rsp_t result
);

	`include "running_median_assert.svh"

	localparam int SW     = SAMPLE_WIDTH;
	localparam int CW     = $clog2(CAPACITY + 1);
	localparam int LOG    = $clog2(CAPACITY);
	localparam int LEAVES = 2 ** LOG;
	localparam int WW     = $clog2(LOG + 1);

	rmed_state_t state_q, state_d;
	logic [WW-1:0] wait_q;
	logic [CW-1:0] count_q, count_base;
	logic          dropped_q, drop;
	logic          accept, load_out;

	logic signed [SW-1:0] x;
	logic signed [SW-1:0] cell_val [CAPACITY];
	logic [CAPACITY-1:0]  cell_gt;
	logic [SW-1:0]        lo_leaf [LEAVES];
	logic [SW-1:0]        hi_leaf [LEAVES];
	logic [SW-1:0]        lo_root, hi_root;
	logic [CW-1:0]        lo_idx, hi_idx;

	logic signed [SW:0]   sum, adj;
	logic signed [SW-1:0] med;

	assign accept     = sample_valid && !sample_stall;
	assign x          = sample_req.sample[SW-1:0];
	assign count_base = sample_req.start_new ? '0 : count_q;
	assign drop       = !sample_req.start_new && (count_q == CW'(CAPACITY));

	// Sorted cell row
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		rmed_cell_ctl_t ctl;
		logic signed [SW-1:0] prev_val;
		logic                 prev_gt;

		assign ctl.wr   = accept && !drop;
		assign ctl.held = CW'(i) < count_base;
		assign ctl.tail = CW'(i) == count_base;

		if (i == 0) begin : g_first
			assign prev_val = '0;
			assign prev_gt  = 1'b0;
		end else begin : g_rest
			assign prev_val = cell_val[i-1];
			assign prev_gt  = cell_gt[i-1];
		end

		rmed_cell #(.SW(SW)) u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.x        (x),
			.prev_val (prev_val),
			.prev_gt  (prev_gt),
			.val      (cell_val[i]),
			.gt       (cell_gt[i])
		);
	end

	// Middle pair: lower at (n-1)/2, upper at n/2; equal for an odd count.
	assign lo_idx = (count_q - CW'(1)) >> 1;
	assign hi_idx = count_q >> 1;

	for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
		if (i < CAPACITY) begin : g_used
			assign lo_leaf[i] = (CW'(i) == lo_idx) ? cell_val[i] : '0;
			assign hi_leaf[i] = (CW'(i) == hi_idx) ? cell_val[i] : '0;
		end else begin : g_pad
			assign lo_leaf[i] = '0;
			assign hi_leaf[i] = '0;
		end
	end

	rmed_or_tree #(.LEAVES(LEAVES), .W(SW)) u_lo_tree (
		.clk  (clk),
		.leaf (lo_leaf),
		.root (lo_root)
	);

	rmed_or_tree #(.LEAVES(LEAVES), .W(SW)) u_hi_tree (
		.clk  (clk),
		.leaf (hi_leaf),
		.root (hi_root)
	);

	// Average with truncation toward zero: add one to a negative odd sum.
	assign sum = (SW+1)'($signed(lo_root)) + (SW+1)'($signed(hi_root));
	assign adj = sum + $signed({{SW{1'b0}}, sum[SW]});
	assign med = adj[SW:1];

	// Control
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			RMED_IDLE: begin
				if (accept) begin
					state_d = RMED_WAIT;
				end
			end
			RMED_WAIT: begin
				if (wait_q == WW'(LOG)) begin
					state_d = RMED_FINISH;
				end
			end
			RMED_FINISH: begin
				if (load_out) begin
					state_d = RMED_IDLE;
				end
			end
			default: state_d = RMED_IDLE;
		endcase
	end

	always_comb begin
		sample_stall = (state_q != RMED_IDLE);
		load_out     = (state_q == RMED_FINISH) && (!result_valid || !result_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= RMED_IDLE;
			wait_q       <= '0;
			count_q      <= '0;
			dropped_q    <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == RMED_WAIT) begin
				wait_q <= wait_q + WW'(1);
			end else begin
				wait_q <= '0;
			end
			if (accept) begin
				count_q   <= drop ? count_q : count_base + CW'(1);
				dropped_q <= drop;
			end
			if (load_out) begin
				result_valid <= 1'b1;
			end else if (!result_stall) begin
				result_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			result.median_out   <= 32'(med);
			result.sample_count <= 7'(count_q);
			result.dropped      <= dropped_q;
		end
	end

	`RMED_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CW'(CAPACITY), "fill count beyond capacity")
	`RMED_ASSERT_NXT(a_accept_waits, accept, state_q == RMED_WAIT, "accept did not start the wait")
	`RMED_ASSERT_NXT(a_full_holds, accept && drop, count_q == $past(count_q), "full store changed count")
	`RMED_ASSERT_IMP(a_result_source, $rose(result_valid), $past(state_q) == RMED_FINISH,
		"result raised outside the final step")

endmodule

// File: design/rmed_cell.sv
`timescale 1ns / 1ps

module rmed_cell
	import rmed_pkg::*;
#(
	parameter int SW = 32
) (
	input  logic                 clk,
	input  rmed_cell_ctl_t       ctl,
	input  logic signed [SW-1:0] x,
	input  logic signed [SW-1:0] prev_val,
	input  logic                 prev_gt,
	output logic signed [SW-1:0] val,
	output logic                 gt
);

	logic signed [SW-1:0] val_q;

	assign val = val_q;
	assign gt  = ctl.held && (val_q > x);

	// Shift up from the left neighbor past the insertion point, take x at it.
	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			if (prev_gt) begin
				val_q <= prev_val;
			end else if (gt || ctl.tail) begin
				val_q <= x;
			end
		end
	end

endmodule

// File: design/rmed_or_tree.sv
`timescale 1ns / 1ps

module rmed_or_tree #(
	parameter int LEAVES = 64,
	parameter int W      = 32
) (
	input  logic         clk,
	input  logic [W-1:0] leaf [LEAVES],
	output logic [W-1:0] root
);

	// Heap-ordered nodes; node 1 is the root, leaves sit at LEAVES and up.
	logic [W-1:0] node_q [1:2*LEAVES-1];

	for (genvar k = 1; k < 2*LEAVES; k++) begin : g_node
		if (k >= LEAVES) begin : g_leaf
			always_ff @(posedge clk) begin
				node_q[k] <= leaf[k-LEAVES];
			end
		end else begin : g_inner
			always_ff @(posedge clk) begin
				node_q[k] <= node_q[2*k] | node_q[2*k+1];
			end
		end
	end

	assign root = node_q[1];

endmodule
